// ===== hdl/tpbe_pkg.sv =====
// Shared types, character codes, character class helpers and a hex digit value helper for the packet byte encoder.
`timescale 1ns / 1ps

package tpbe_pkg;

    typedef enum logic [7:0] {
        MODE_IDLE    = 8'b0000_0001,
        MODE_NAME    = 8'b0000_0010,
        MODE_COMMENT = 8'b0000_0100,
        MODE_ESCAPE  = 8'b0000_1000,
        MODE_HEX     = 8'b0001_0000,
        MODE_NUMBER  = 8'b0010_0000,
        MODE_FLOAT   = 8'b0100_0000,
        MODE_HALT    = 8'b1000_0000
    } t_mode;

    typedef enum logic [1:0] {
        KIND_BYTE = 2'd0,
        KIND_WORD = 2'd1,
        KIND_INT  = 2'd2
    } t_kind;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_BSL   = 8'h5C;
    localparam logic [7:0] CH_B     = 8'h62;
    localparam logic [7:0] CH_F     = 8'h66;
    localparam logic [7:0] CH_W     = 8'h77;
    localparam logic [7:0] CH_X     = 8'h78;

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    function automatic logic is_graph(input logic [7:0] c);
        return (c >= 8'h21) && (c <= 8'h7E);
    endfunction

    function automatic logic is_hex(input logic [7:0] c);
        return is_digit(c) || ((c >= 8'h61) && (c <= 8'h66)) || ((c >= 8'h41) && (c <= 8'h46));
    endfunction

    function automatic logic [3:0] hex_value(input logic [7:0] c);
        logic [7:0] v;
        v = 8'h00;
        if (is_digit(c)) begin
            v = c - 8'h30;
        end else if ((c >= 8'h61) && (c <= 8'h66)) begin
            v = c - 8'h57;
        end else if ((c >= 8'h41) && (c <= 8'h46)) begin
            v = c - 8'h37;
        end
        return v[3:0];
    endfunction

endpackage

// ===== hdl/text_to_packet_byte_encoder_core.sv =====
// Text to packet byte encoder: character parser and result byte serializer.
// A result byte appears in the cycle after its character is transferred in.
// Throughput: one character per cycle while each yields at most one byte and the
// output is ready; else input waits until the one-byte port takes the last byte.
// Reset: synchronous active low; parser idle, result buffer empty, byte_swap set to 1.
`timescale 1ns / 1ps

module text_to_packet_byte_encoder_core (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic       i_cfg_data,        // byte_swap
    input  logic       i_s_axis_tvalid,
    output logic       o_s_axis_tready,
    input  logic [7:0] i_s_axis_tdata,    // ch
    input  logic       i_s_axis_tlast,    // text_last
    output logic       o_m_axis_tvalid,
    input  logic       i_m_axis_tready,
    output logic [7:0] o_m_axis_tdata,    // data_byte
    output logic       o_m_axis_tlast     // run_last
);
    import tpbe_pkg::*;

    t_mode       r_mode, n_mode;
    t_kind       r_kind, n_kind;
    logic        r_neg, n_neg;
    logic        r_sa, n_sa;
    logic        r_fs, n_fs;
    logic [31:0] r_acc, n_acc;
    logic [3:0]  r_hhn, n_hhn;
    logic        r_hh, n_hh;
    logic        r_swap;

    logic        take_flush, start, emit_ch, fl_en;
    logic [7:0]  ch_val;
    t_mode       fl_mode;
    t_kind       fl_kind;
    logic        fl_neg, fl_hh;
    logic [31:0] fl_acc;
    logic [3:0]  fl_hhn;
    logic [2:0]  fb_n;
    logic [31:0] fb_acc;
    logic        fb_neg;

    logic [2:0]  r_fl_n, r_total, r_idx;
    logic [31:0] r_fl_acc;
    logic        r_fl_neg;
    logic [7:0]  r_ch;

    logic        in_fire, out_fire;
    logic [7:0]  c;
    logic [31:0] w_val;
    logic [2:0]  w_npos, w_end;
    logic [1:0]  w_pos;
    logic [7:0]  w_fbyte;

    assign c = i_s_axis_tdata;

    always_comb begin
        n_mode = r_mode;
        n_kind = r_kind;
        n_neg = r_neg;
        n_sa = r_sa;
        n_fs = r_fs;
        n_acc = r_acc;
        n_hhn = r_hhn;
        n_hh = r_hh;
        take_flush = 1'b0;
        start = 1'b0;
        emit_ch = 1'b0;
        ch_val = c;

        unique case (r_mode)
            MODE_IDLE: begin
                start = 1'b1;
            end
            MODE_NAME: begin
                if (is_graph(c) && (c != CH_BSL)) begin
                    emit_ch = 1'b1;
                end else begin
                    start = 1'b1;
                end
            end
            MODE_COMMENT: begin
                if (c == CH_LF) begin
                    n_mode = MODE_IDLE;
                end else if (c == CH_NUL) begin
                    n_mode = MODE_HALT;
                end
            end
            MODE_ESCAPE: begin
                n_kind = KIND_BYTE;
                n_neg = 1'b0;
                n_sa = 1'b0;
                n_fs = 1'b0;
                n_acc = 32'd0;
                n_hhn = 4'd0;
                n_hh = 1'b0;
                priority if (c == CH_X) begin
                    n_mode = MODE_HEX;
                end else if ((c == CH_B) || (c == CH_W)) begin
                    n_mode = MODE_NUMBER;
                    n_kind = (c == CH_B) ? KIND_BYTE : KIND_WORD;
                    n_sa = 1'b1;
                end else if (c == CH_F) begin
                    n_mode = MODE_FLOAT;
                    n_sa = 1'b1;
                end else if (c == CH_MINUS) begin
                    n_mode = MODE_NUMBER;
                    n_kind = KIND_INT;
                    n_neg = 1'b1;
                end else if (is_digit(c)) begin
                    n_mode = MODE_NUMBER;
                    n_kind = KIND_INT;
                    n_acc = {28'd0, c[3:0]};
                end else if (c == CH_NUL) begin
                    n_mode = MODE_HALT;
                end else begin
                    emit_ch = 1'b1;
                    n_mode = MODE_IDLE;
                end
            end
            MODE_HEX: begin
                if (is_hex(c)) begin
                    if (r_hh) begin
                        emit_ch = 1'b1;
                        ch_val = {r_hhn, hex_value(c)};
                        n_hh = 1'b0;
                        n_hhn = 4'd0;
                    end else begin
                        n_hhn = hex_value(c);
                        n_hh = 1'b1;
                    end
                end else begin
                    take_flush = 1'b1;
                end
            end
            MODE_NUMBER: begin
                if (r_sa && (c == CH_MINUS)) begin
                    n_neg = 1'b1;
                    n_sa = 1'b0;
                end else if (is_digit(c)) begin
                    n_acc = {r_acc[28:0], 3'b000} + {r_acc[30:0], 1'b0} + {28'd0, c[3:0]};
                    n_sa = 1'b0;
                end else begin
                    take_flush = 1'b1;
                end
            end
            MODE_FLOAT: begin
                if (r_sa && (c == CH_MINUS)) begin
                    n_sa = 1'b0;
                end else if (is_digit(c)) begin
                    n_sa = 1'b0;
                end else if ((c == CH_DOT) && !r_fs) begin
                    n_sa = 1'b0;
                    n_fs = 1'b1;
                end else begin
                    take_flush = 1'b1;
                end
            end
            MODE_HALT: begin
            end
            default: begin
            end
        endcase

        if (take_flush) begin
            n_mode = MODE_IDLE;
            n_kind = KIND_BYTE;
            n_neg = 1'b0;
            n_sa = 1'b0;
            n_fs = 1'b0;
            n_acc = 32'd0;
            n_hhn = 4'd0;
            n_hh = 1'b0;
            start = 1'b1;
        end

        if (start) begin
            priority if ((c == CH_SPACE) || (c == CH_TAB) || (c == CH_LF)) begin
                n_mode = MODE_IDLE;
            end else if (c == CH_HASH) begin
                n_mode = MODE_COMMENT;
            end else if (c == CH_BSL) begin
                n_mode = MODE_ESCAPE;
            end else if (is_graph(c)) begin
                emit_ch = 1'b1;
                ch_val = c;
                n_mode = MODE_NAME;
            end else begin
                n_mode = MODE_HALT;
            end
        end

        fl_en = take_flush || i_s_axis_tlast;
        if (take_flush) begin
            fl_mode = r_mode;
            fl_kind = r_kind;
            fl_neg = r_neg;
            fl_acc = r_acc;
            fl_hh = r_hh;
            fl_hhn = r_hhn;
        end else begin
            fl_mode = n_mode;
            fl_kind = n_kind;
            fl_neg = n_neg;
            fl_acc = n_acc;
            fl_hh = n_hh;
            fl_hhn = n_hhn;
        end

        if (i_s_axis_tlast) begin
            n_mode = MODE_IDLE;
            n_kind = KIND_BYTE;
            n_neg = 1'b0;
            n_sa = 1'b0;
            n_fs = 1'b0;
            n_acc = 32'd0;
            n_hhn = 4'd0;
            n_hh = 1'b0;
        end

        fb_n = 3'd0;
        fb_acc = fl_acc;
        fb_neg = fl_neg;
        if (fl_en && (fl_mode == MODE_HEX) && fl_hh) begin
            fb_n = 3'd1;
            fb_acc = {28'd0, fl_hhn};
            fb_neg = 1'b0;
        end else if (fl_en && (fl_mode == MODE_NUMBER)) begin
            unique case (fl_kind)
                KIND_BYTE: fb_n = 3'd1;
                KIND_WORD: fb_n = 3'd2;
                KIND_INT:  fb_n = 3'd4;
                default:   fb_n = 3'd1;
            endcase
        end
    end

    assign w_val = r_fl_neg ? (32'd0 - r_fl_acc) : r_fl_acc;
    assign w_npos = r_fl_n - 3'd1;
    assign w_end = r_total - 3'd1;
    assign w_pos = (r_swap && (r_fl_n > 3'd1)) ? (w_npos[1:0] - r_idx[1:0]) : r_idx[1:0];

    always_comb begin
        unique case (w_pos)
            2'd0: w_fbyte = w_val[7:0];
            2'd1: w_fbyte = w_val[15:8];
            2'd2: w_fbyte = w_val[23:16];
            2'd3: w_fbyte = w_val[31:24];
            default: w_fbyte = w_val[7:0];
        endcase
    end

    assign o_m_axis_tvalid = (r_total != 3'd0);
    assign o_m_axis_tdata = (r_idx < r_fl_n) ? w_fbyte : r_ch;
    assign o_m_axis_tlast = (r_idx == w_end);
    assign out_fire = o_m_axis_tvalid && i_m_axis_tready;
    assign o_s_axis_tready = (r_total == 3'd0) || (i_m_axis_tready && o_m_axis_tlast);
    assign in_fire = i_s_axis_tvalid && o_s_axis_tready;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_IDLE;
            r_kind <= KIND_BYTE;
            r_neg <= 1'b0;
            r_sa <= 1'b0;
            r_fs <= 1'b0;
            r_acc <= 32'd0;
            r_hhn <= 4'd0;
            r_hh <= 1'b0;
            r_swap <= 1'b1;
            r_total <= 3'd0;
            r_idx <= 3'd0;
        end else begin
            if (i_cfg_valid) begin
                r_swap <= i_cfg_data;
            end
            if (in_fire) begin
                r_mode <= n_mode;
                r_kind <= n_kind;
                r_neg <= n_neg;
                r_sa <= n_sa;
                r_fs <= n_fs;
                r_acc <= n_acc;
                r_hhn <= n_hhn;
                r_hh <= n_hh;
                r_total <= fb_n + {2'b00, emit_ch};
                r_idx <= 3'd0;
            end else if (out_fire) begin
                if (o_m_axis_tlast) begin
                    r_total <= 3'd0;
                end else begin
                    r_idx <= r_idx + 3'd1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_fl_n <= fb_n;
            r_fl_acc <= fb_acc;
            r_fl_neg <= fb_neg;
            r_ch <= ch_val;
        end
    end

endmodule
